// ===== hw/rtl/ise_pkg.sv =====
// ise_pkg: shared types, constants and codes of the impulse segmenter.
// Used by ise_front, ise_queue, ise_back and the top level.
package ise_pkg;

    localparam int MAX_SEGMENT = 4096;
    localparam int MAX_POINTS  = 32;
    localparam int MIN_SEGMENT = 100;
    localparam int MIN_TARGET  = 10;

    localparam int SMP_W   = 16;
    localparam int CNT_W   = 13;
    localparam int OFF_W   = 12;
    localparam int PNT_W   = 6;
    localparam int WAV_W   = 10;
    localparam int XIDX_W  = $clog2(MAX_POINTS);
    localparam int XADR_W  = XIDX_W + 1;   // bank bit on top
    localparam int CFGD_W  = 16;
    localparam int CFGI_W  = 3;

    // register indexes of the configuration port
    typedef enum logic [CFGI_W-1:0] {
        CFG_SEGMENT_LIMIT    = 3'd0,
        CFG_MIN_IMPULSE_LEN  = 3'd1,
        CFG_END_LEVEL        = 3'd2,
        CFG_MAX_POINTS       = 3'd3,
        CFG_TARGET_WAVEFORMS = 3'd4
    } t_cfg_reg;

    typedef enum logic [2:0] {
        KIND_BASE   = 3'd0,
        KIND_EDGE   = 3'd1,
        KIND_PEAK   = 3'd2,
        KIND_VALLEY = 3'd3,
        KIND_END    = 3'd4
    } t_kind;

    // one extremum in the store
    typedef struct packed {
        logic [OFF_W-1:0]        offset;
        logic signed [SMP_W-1:0] value;
    } t_xtrm;

    // write port of the extremum store, front to back
    typedef struct packed {
        logic              we;
        logic [XADR_W-1:0] addr;
        t_xtrm             data;
    } t_xwr;

    // one accepted waveform, handed from front to back
    typedef struct packed {
        logic                    bank;
        logic [WAV_W-1:0]        wnum;
        logic                    first_peak;
        logic [PNT_W-1:0]        n_ext;
        logic [PNT_W-1:0]        total;
        logic signed [SMP_W-1:0] first_smp;
        logic [OFF_W-1:0]        end_off;
        logic signed [SMP_W-1:0] end_smp;
        logic                    done;
    } t_burst;

endpackage

// ===== hw/rtl/ise_front.sv =====
// ise_front: accepts sample/start words, tracks impulses, marks extrema
// and pushes one burst word per accepted waveform. Depends on ise_pkg.
module ise_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_req_type,
    input  logic signed [ise_pkg::SMP_W-1:0]  i_sample_value,
    input  logic                              i_cfg_we,
    input  logic [ise_pkg::CFGI_W-1:0]        i_cfg_idx,
    input  logic [ise_pkg::CFGD_W-1:0]        i_cfg_data,
    input  logic                              i_full,
    output logic                              o_push,
    output ise_pkg::t_burst                   o_burst,
    output ise_pkg::t_xwr                     o_xwr
);

    localparam logic [ise_pkg::CNT_W-1:0] SEG_MAX  = ise_pkg::CNT_W'(ise_pkg::MAX_SEGMENT);
    localparam logic [ise_pkg::CNT_W-1:0] SEG_MIN  = ise_pkg::CNT_W'(ise_pkg::MIN_SEGMENT);
    localparam logic [ise_pkg::PNT_W-1:0] PNT_MAX  = ise_pkg::PNT_W'(ise_pkg::MAX_POINTS);
    localparam logic [ise_pkg::WAV_W-1:0] TGT_MIN  = ise_pkg::WAV_W'(ise_pkg::MIN_TARGET);

    // configuration
    logic [ise_pkg::CNT_W-1:0]   r_seg_limit;
    logic [ise_pkg::OFF_W-1:0]   r_min_len;
    logic [15:0]                 r_end_level;
    logic [ise_pkg::PNT_W-1:0]   r_max_points;
    logic [ise_pkg::WAV_W-1:0]   r_target;

    // impulse state; edge_seen always equals r_active, so one flop serves both
    logic                              r_measuring, n_measuring;
    logic                              r_active,    n_active;
    logic signed [ise_pkg::SMP_W-1:0]  r_prev,      n_prev;
    logic [ise_pkg::CNT_W-1:0]         r_cnt,       n_cnt;
    logic signed [ise_pkg::SMP_W-1:0]  r_win [4];
    logic signed [ise_pkg::SMP_W-1:0]  n_win [4];
    logic signed [ise_pkg::SMP_W-1:0]  r_first,     n_first;
    logic [ise_pkg::PNT_W-1:0]         r_ecnt,      n_ecnt;
    logic                              r_first_peak, n_first_peak;
    logic [ise_pkg::WAV_W-1:0]         r_wc,        n_wc;
    logic                              r_wbank,     n_wbank;

    logic                              acc, smp_acc;
    logic                              edge_hit, act, store, ext_hit, hi, lo;
    logic                              end_hit, emit, has_end;
    logic [ise_pkg::CNT_W-1:0]         lim, cnt, cnt_after;
    logic [ise_pkg::PNT_W-1:0]         ecnt, cap, room, n_ext;
    logic signed [ise_pkg::SMP_W-1:0]  x, c;
    logic [ise_pkg::SMP_W:0]           mag;

    assign o_stall = i_full;
    assign acc     = i_valid && !i_full;
    assign smp_acc = acc && !i_req_type && r_measuring;
    assign x       = i_sample_value;
    assign c       = r_win[1];

    always_comb begin
        n_measuring  = r_measuring;
        n_active     = r_active;
        n_prev       = r_prev;
        n_cnt        = r_cnt;
        n_win        = r_win;
        n_first      = r_first;
        n_ecnt       = r_ecnt;
        n_first_peak = r_first_peak;
        n_wc         = r_wc;
        n_wbank      = r_wbank;
        o_push       = 1'b0;
        o_xwr        = '0;
        o_burst      = '0;

        lim       = (r_seg_limit > SEG_MAX) ? SEG_MAX : r_seg_limit;
        edge_hit  = !r_active && (r_prev < 0) && (x >= 0);
        act       = r_active || edge_hit;
        cnt       = edge_hit ? '0 : r_cnt;
        ecnt      = edge_hit ? '0 : r_ecnt;
        store     = act && (cnt < lim);
        hi        = (c > r_win[0]) && (c > r_win[2]) && (c > r_win[3]) && (c > x);
        lo        = (c < r_win[0]) && (c < r_win[2]) && (c < r_win[3]) && (c < x);
        ext_hit   = store && (cnt >= ise_pkg::CNT_W'(4)) && (hi || lo) && (ecnt < PNT_MAX);
        cnt_after = cnt + ise_pkg::CNT_W'(store);
        mag       = (x < 0) ? -{x[ise_pkg::SMP_W-1], x} : {1'b0, x};
        end_hit   = act && (cnt_after > {1'b0, r_min_len})
                    && (mag < {1'b0, r_end_level});
        emit      = end_hit && (cnt_after >= SEG_MIN);

        cap       = (r_max_points > PNT_MAX) ? PNT_MAX : r_max_points;
        room      = (cap > ise_pkg::PNT_W'(2)) ? cap - ise_pkg::PNT_W'(2) : '0;

        if (acc && i_req_type) begin
            n_measuring = 1'b1;
            n_wc        = '0;
        end else if (smp_acc) begin
            n_prev   = x;
            n_active = act;
            n_cnt    = cnt;
            n_ecnt   = ecnt;
            if (store) begin
                if (cnt == '0) begin
                    n_first = x;
                end
                n_win[3] = r_win[2];
                n_win[2] = r_win[1];
                n_win[1] = r_win[0];
                n_win[0] = x;
                n_cnt    = cnt_after;
            end
            if (ext_hit) begin
                o_xwr.we          = 1'b1;
                o_xwr.addr        = {r_wbank, ecnt[ise_pkg::XIDX_W-1:0]};
                o_xwr.data.offset = ise_pkg::OFF_W'(cnt - ise_pkg::CNT_W'(2));
                o_xwr.data.value  = c;
                n_ecnt            = ecnt + ise_pkg::PNT_W'(1);
                if (ecnt == '0) begin
                    n_first_peak = (c > 0);
                end
            end
            if (end_hit) begin
                n_active = 1'b0;
            end
            if (emit) begin
                n_wc                = r_wc + ise_pkg::WAV_W'(1);
                n_wbank             = !r_wbank;
                o_push              = 1'b1;
                o_burst.bank        = r_wbank;
                o_burst.wnum        = n_wc;
                o_burst.first_peak  = n_first_peak;
                o_burst.first_smp   = n_first;
                o_burst.end_off     = ise_pkg::OFF_W'(cnt_after - ise_pkg::CNT_W'(1));
                o_burst.end_smp     = n_win[0];
                o_burst.done        = (n_wc >= r_target) && (n_wc >= TGT_MIN);
                if (o_burst.done) begin
                    n_measuring = 1'b0;
                end
            end
        end

        n_ext         = (n_ecnt < room) ? n_ecnt : room;
        has_end       = (n_ext + ise_pkg::PNT_W'(2)) < cap;
        o_burst.n_ext = emit ? n_ext : '0;
        o_burst.total = emit ? n_ext + ise_pkg::PNT_W'(2) + ise_pkg::PNT_W'(has_end) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_limit  <= ise_pkg::CNT_W'(2048);
            r_min_len    <= ise_pkg::OFF_W'(200);
            r_end_level  <= 16'd1638;
            r_max_points <= ise_pkg::PNT_W'(32);
            r_target     <= ise_pkg::WAV_W'(20);
        end else if (i_cfg_we) begin
            case (ise_pkg::t_cfg_reg'(i_cfg_idx))
                ise_pkg::CFG_SEGMENT_LIMIT:    r_seg_limit  <= i_cfg_data[ise_pkg::CNT_W-1:0];
                ise_pkg::CFG_MIN_IMPULSE_LEN:  r_min_len    <= i_cfg_data[ise_pkg::OFF_W-1:0];
                ise_pkg::CFG_END_LEVEL:        r_end_level  <= i_cfg_data;
                ise_pkg::CFG_MAX_POINTS:       r_max_points <= i_cfg_data[ise_pkg::PNT_W-1:0];
                ise_pkg::CFG_TARGET_WAVEFORMS: r_target     <= i_cfg_data[ise_pkg::WAV_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_measuring  <= 1'b0;
            r_active     <= 1'b0;
            r_prev       <= '0;
            r_cnt        <= '0;
            r_win        <= '{default: '0};
            r_first      <= '0;
            r_ecnt       <= '0;
            r_first_peak <= 1'b0;
            r_wc         <= '0;
            r_wbank      <= 1'b0;
        end else begin
            r_measuring  <= n_measuring;
            r_active     <= n_active;
            r_prev       <= n_prev;
            r_cnt        <= n_cnt;
            r_win        <= n_win;
            r_first      <= n_first;
            r_ecnt       <= n_ecnt;
            r_first_peak <= n_first_peak;
            r_wc         <= n_wc;
            r_wbank      <= n_wbank;
        end
    end

endmodule

// ===== hw/rtl/ise_queue.sv =====
// ise_queue: two-entry queue of burst words between front and back.
// Depends on ise_pkg.
module ise_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ise_pkg::t_burst i_data,
    input  logic            i_pop,
    output logic            o_valid,
    output ise_pkg::t_burst o_data,
    output logic [1:0]      o_count
);

    ise_pkg::t_burst r_mem [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_count;

    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

// ===== hw/rtl/ise_back.sv =====
// ise_back: holds the two-bank extremum store and plays one burst word
// out as a run of point words. Depends on ise_pkg.
module ise_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ise_pkg::t_xwr                    i_xwr,
    input  logic                             i_q_valid,
    input  ise_pkg::t_burst                  i_q_data,
    output logic                             o_pop,
    output logic                             o_busy,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [ise_pkg::WAV_W-1:0]        o_waveform_number,
    output logic [ise_pkg::PNT_W-1:0]        o_point_number,
    output logic [2:0]                       o_point_kind,
    output logic [ise_pkg::OFF_W-1:0]        o_sample_offset,
    output logic signed [ise_pkg::SMP_W-1:0] o_point_sample,
    output logic                             o_last_point,
    output logic                             o_measurement_done
);

    typedef enum logic [1:0] {
        BS_IDLE = 2'b01,
        BS_RUN  = 2'b10
    } t_bst;

    ise_pkg::t_xtrm  r_xmem [2**ise_pkg::XADR_W];
    ise_pkg::t_xtrm  r_rdata;

    t_bst                       r_st,   n_st;
    ise_pkg::t_burst            r_desc, n_desc;
    logic [ise_pkg::PNT_W-1:0]  r_p,    n_p;
    logic [ise_pkg::PNT_W-1:0]  rd_idx, xi;
    logic                       adv, is_last, is_ext;
    ise_pkg::t_kind             kind;
    logic [ise_pkg::OFF_W-1:0]  off;
    logic signed [ise_pkg::SMP_W-1:0] smp;

    assign o_busy  = (r_st == BS_RUN);
    assign adv     = (r_st == BS_RUN) && (!o_valid || !i_stall);
    assign is_last = (r_p == r_desc.total - ise_pkg::PNT_W'(1));

    always_comb begin
        n_st   = r_st;
        n_desc = r_desc;
        n_p    = r_p;
        o_pop  = 1'b0;
        case (r_st)
            BS_IDLE: begin
                if (i_q_valid) begin
                    o_pop  = 1'b1;
                    n_desc = i_q_data;
                    n_p    = '0;
                    n_st   = BS_RUN;
                end
            end
            BS_RUN: begin
                if (adv) begin
                    if (is_last) begin
                        n_st = BS_IDLE;
                    end else begin
                        n_p = r_p + ise_pkg::PNT_W'(1);
                    end
                end
            end
            default: n_st = BS_IDLE;
        endcase
        // read ahead so r_rdata always belongs to r_p
        rd_idx = n_p - ise_pkg::PNT_W'(2);
    end

    // point decode
    always_comb begin
        xi     = r_p - ise_pkg::PNT_W'(2);
        is_ext = (r_p >= ise_pkg::PNT_W'(2)) && (xi < r_desc.n_ext);
        kind   = ise_pkg::KIND_END;
        off    = r_desc.end_off;
        smp    = r_desc.end_smp;
        if (r_p == '0) begin
            kind = ise_pkg::KIND_BASE;
            off  = '0;
            smp  = r_desc.first_smp;
        end else if (r_p == ise_pkg::PNT_W'(1)) begin
            kind = ise_pkg::KIND_EDGE;
            off  = '0;
            smp  = r_desc.first_smp;
        end else if (is_ext) begin
            kind = (r_desc.first_peak ^ xi[0]) ? ise_pkg::KIND_PEAK : ise_pkg::KIND_VALLEY;
            off  = r_rdata.offset;
            smp  = r_rdata.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_xwr.we) begin
            r_xmem[i_xwr.addr] <= i_xwr.data;
        end
        r_rdata <= r_xmem[{n_desc.bank, rd_idx[ise_pkg::XIDX_W-1:0]}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= BS_IDLE;
            r_p     <= '0;
            o_valid <= 1'b0;
        end else begin
            r_st <= n_st;
            r_p  <= n_p;
            if (adv) begin
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_desc <= n_desc;
        if (adv) begin
            o_waveform_number  <= r_desc.wnum;
            o_point_number     <= r_p + ise_pkg::PNT_W'(1);
            o_point_kind       <= kind;
            o_sample_offset    <= off;
            o_point_sample     <= smp;
            o_last_point       <= is_last;
            o_measurement_done <= is_last && r_desc.done;
        end
    end

endmodule

// ===== hw/rtl/impulse_segmenter_extrema_marker_unit.sv =====
// impulse_segmenter_extrema_marker_unit: top level of the impulse segmenter.
// Instantiates ise_front, ise_queue and ise_back; depends on ise_pkg.
//
// Usage
//   Input channel (i_valid / o_stall): one word per cycle unless stalled,
//   either an audio sample (i_req_type 0) or a start request (i_req_type 1),
//   which arms the measurement and clears the waveform count.
//   Output channel (o_valid / i_stall): one word per point. A sample that
//   closes an accepted waveform (100+ stored samples) yields a burst of
//   2..32 point words: baseline, rising edge, alternating peak/valley
//   extrema, end. o_last_point marks the final word of a burst, and
//   o_measurement_done rides on it when the count reaches target and 10.
//   A burst reaches o_valid through the queue, the back end's run state and
//   the output register; then one point per cycle while not stalled.
//   Throughput: one sample per cycle unless stalled. The extremum store has
//   two banks, so up to two bursts can be outstanding (queued or draining);
//   o_stall is high only while both banks are held by bursts not yet drained.
//   Receiver stall: the output register holds its word; the back end stops,
//   the front end keeps taking samples until both banks are held.
//   Reset (synchronous, active low): config registers return to their
//   defaults, measurement is off, queue and back end are emptied. The
//   extremum store is not cleared; it is always written before it is read.
//   Config writes (i_cfg_we) take effect at once; write only while idle.
module impulse_segmenter_extrema_marker_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_req_type,
    input  logic signed [ise_pkg::SMP_W-1:0] i_sample_value,
    input  logic                             i_cfg_we,
    input  logic [ise_pkg::CFGI_W-1:0]       i_cfg_idx,
    input  logic [ise_pkg::CFGD_W-1:0]       i_cfg_data,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [ise_pkg::WAV_W-1:0]        o_waveform_number,
    output logic [ise_pkg::PNT_W-1:0]        o_point_number,
    output logic [2:0]                       o_point_kind,
    output logic [ise_pkg::OFF_W-1:0]        o_sample_offset,
    output logic signed [ise_pkg::SMP_W-1:0] o_point_sample,
    output logic                             o_last_point,
    output logic                             o_measurement_done
);

    logic            push, pop, q_valid, busy, full;
    logic [1:0]      q_count;
    ise_pkg::t_burst push_data, q_data;
    ise_pkg::t_xwr   xwr;

    // bursts outstanding = queued + draining; two means both banks held
    assign full = (q_count + 2'(busy)) >= 2'd2;

    ise_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_sample_value (i_sample_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_full         (full),
        .o_push         (push),
        .o_burst        (push_data),
        .o_xwr          (xwr)
    );

    ise_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_data),
        .o_count (q_count)
    );

    ise_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_xwr              (xwr),
        .i_q_valid          (q_valid),
        .i_q_data           (q_data),
        .o_pop              (pop),
        .o_busy             (busy),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_waveform_number  (o_waveform_number),
        .o_point_number     (o_point_number),
        .o_point_kind       (o_point_kind),
        .o_sample_offset    (o_sample_offset),
        .o_point_sample     (o_point_sample),
        .o_last_point       (o_last_point),
        .o_measurement_done (o_measurement_done)
    );

    // never more than two bursts hold the two store banks
    a_banks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_count + 2'(busy)) <= 2'd2)
        else $error("more bursts outstanding than store banks");

    // a push never lands on a full queue
    a_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (q_count != 2'd2))
        else $error("burst pushed into full queue");

    // the done flag only appears on the last point of a burst
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_measurement_done) |-> o_last_point)
        else $error("done flag away from last point");

    // every burst opens with the baseline point
    a_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_point_number == ise_pkg::PNT_W'(1)))
            |-> (o_point_kind == ise_pkg::KIND_BASE))
        else $error("burst does not open with baseline");

    // a write into the store only when the front may own its bank
    a_xwr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xwr.we |-> !full)
        else $error("store written while both banks held");

endmodule

// ===== test/impulse_segmenter_extrema_marker_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for impulse_segmenter_extrema_marker_unit.
// Needs ise_pkg and the unit; a scoreboard class predicts every point word.
module impulse_segmenter_extrema_marker_unit_tb;
    import ise_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam bit          REQ_SAMPLE    = 1'b0;
    localparam bit          REQ_START     = 1'b1;

    // one point word as it leaves the block
    typedef struct packed {
        logic [WAV_W-1:0]        wnum;
        logic [PNT_W-1:0]        pnum;
        logic [2:0]              kind;
        logic [OFF_W-1:0]        off;
        logic signed [SMP_W-1:0] smp;
        logic                    last;
        logic                    done;
    } t_point;

    // who idles: sender light / receiver heavy, the reverse, or nobody
    typedef enum {MODE_RX_HEAVY, MODE_TX_HEAVY, MODE_FREE} t_idle_mode;

    // register settings and stimulus budget of one phase
    typedef struct {
        int unsigned lim;
        int unsigned min_len;
        int unsigned end_lvl;
        int unsigned pcap;
        int unsigned target;
        int unsigned budget;
        t_idle_mode  mode;
    } t_phase;

    // Scoreboard: tracks the segmenter state word by word and keeps the
    // point words each accepted sample must produce, oldest first.
    class point_scoreboard;
        int unsigned             seg_limit = 2048;
        int unsigned             min_len   = 200;
        int unsigned             end_lvl   = 1638;
        int unsigned             point_cap = 32;
        int unsigned             target    = 20;
        bit                      measuring;
        bit                      active;
        bit                      edge_seen;
        logic signed [SMP_W-1:0] prev_smp  = '0;
        logic signed [SMP_W-1:0] first_smp = '0;
        logic signed [SMP_W-1:0] win [4]   = '{default: '0};
        int unsigned             stored;
        logic [OFF_W-1:0]        x_off [MAX_POINTS];
        logic signed [SMP_W-1:0] x_val [MAX_POINTS];
        int unsigned             x_count;
        logic [WAV_W-1:0]        wave_count = '0;
        t_point                  pending_points[$];
        int unsigned             failures;

        function void set_register(t_cfg_reg r, int unsigned v);
            case (r)
                CFG_SEGMENT_LIMIT:    seg_limit = v & 32'h1FFF;
                CFG_MIN_IMPULSE_LEN:  min_len   = v & 32'hFFF;
                CFG_END_LEVEL:        end_lvl   = v & 32'hFFFF;
                CFG_MAX_POINTS:       point_cap = v & 32'h3F;
                CFG_TARGET_WAVEFORMS: target    = v & 32'h3FF;
                default: ;
            endcase
        endfunction

        function t_point make_point(int unsigned idx, logic [2:0] kind,
                                    logic [OFF_W-1:0] off, logic signed [SMP_W-1:0] smp);
            t_point p;
            p.wnum = wave_count;
            p.pnum = PNT_W'(idx + 1);
            p.kind = kind;
            p.off  = off;
            p.smp  = smp;
            p.last = 1'b0;
            p.done = 1'b0;
            return p;
        endfunction

        // five-point strict extremum test on the middle of the window
        function void store_sample(logic signed [SMP_W-1:0] x);
            logic signed [SMP_W-1:0] c;
            bit hi, lo;
            if (stored >= 4) begin
                c  = win[1];
                hi = c > win[0] && c > win[2] && c > win[3] && c > x;
                lo = c < win[0] && c < win[2] && c < win[3] && c < x;
                if ((hi || lo) && x_count < MAX_POINTS) begin
                    x_off[x_count] = OFF_W'(stored - 2);
                    x_val[x_count] = c;
                    x_count++;
                end
            end
            if (stored == 0)
                first_smp = x;
            win[3] = win[2];
            win[2] = win[1];
            win[1] = win[0];
            win[0] = x;
            stored++;
        endfunction

        function void emit_waveform();
            int unsigned cap;
            int unsigned i;
            bit          peak;
            t_point      burst[$];
            cap = (point_cap > MAX_POINTS) ? MAX_POINTS : point_cap;
            wave_count++;
            burst = {burst, make_point(burst.size(), KIND_BASE, '0, first_smp)};
            burst = {burst, make_point(burst.size(), KIND_EDGE, '0, first_smp)};
            // first extremum decides peak/valley, then kinds just alternate
            peak = x_count > 0 && x_val[0] > 0;
            for (i = 0; i < x_count && burst.size() < cap; i++) begin
                burst = {burst, make_point(burst.size(), peak ? KIND_PEAK : KIND_VALLEY,
                                           x_off[i], x_val[i])};
                peak = !peak;
            end
            if (burst.size() < cap)
                burst = {burst, make_point(burst.size(), KIND_END, OFF_W'(stored - 1),
                                           win[0])};
            burst[burst.size() - 1].last = 1'b1;
            if (wave_count >= target && wave_count >= MIN_TARGET) begin
                measuring = 1'b0;
                burst[burst.size() - 1].done = 1'b1;
            end
            pending_points = {pending_points, burst};
        endfunction

        // called for every accepted input word
        function void predict_points(bit req, logic signed [SMP_W-1:0] x);
            int unsigned lim;
            int unsigned mag;
            lim = (seg_limit > MAX_SEGMENT) ? MAX_SEGMENT : seg_limit;
            if (req == REQ_START) begin
                measuring  = 1'b1;
                wave_count = '0;
                return;
            end
            if (!measuring)
                return;
            if (!edge_seen && prev_smp < 0 && x >= 0) begin
                active    = 1'b1;
                edge_seen = 1'b1;
                stored    = 0;
                x_count   = 0;
            end
            if (active && stored < lim)
                store_sample(x);
            if (active && stored > min_len) begin
                mag = (x < 0) ? -int'(x) : int'(x);
                if (mag < end_lvl) begin
                    active = 1'b0;
                    if (stored >= MIN_SEGMENT)
                        emit_waveform();
                    edge_seen = 1'b0;
                end
            end
            prev_smp = x;
        endfunction

        function void check_point(t_point got);
            t_point want;
            if (pending_points.size() == 0) begin
                $error("point word with nothing pending: waveform %0d point %0d",
                       got.wnum, got.pnum);
                failures++;
                return;
            end
            want = pending_points.pop_front();
            if (got.wnum !== want.wnum) begin
                $error("waveform_number: expected %0d, got %0d", want.wnum, got.wnum);
                failures++;
            end
            if (got.pnum !== want.pnum) begin
                $error("point_number: expected %0d, got %0d", want.pnum, got.pnum);
                failures++;
            end
            if (got.kind !== want.kind) begin
                $error("point_kind: expected %0d, got %0d", want.kind, got.kind);
                failures++;
            end
            if (got.off !== want.off) begin
                $error("sample_offset: expected %0d, got %0d", want.off, got.off);
                failures++;
            end
            if (got.smp !== want.smp) begin
                $error("point_sample: expected %0d, got %0d", want.smp, got.smp);
                failures++;
            end
            if (got.last !== want.last) begin
                $error("last_point: expected %0d, got %0d", want.last, got.last);
                failures++;
            end
            if (got.done !== want.done) begin
                $error("measurement_done: expected %0d, got %0d", want.done, got.done);
                failures++;
            end
        endfunction
    endclass

    // clock, reset and every block input start known
    logic                    i_clk          = 1'b0;
    logic                    i_rst_n        = 1'b0;
    logic                    i_valid        = 1'b0;
    logic                    i_req_type     = REQ_SAMPLE;
    logic signed [SMP_W-1:0] i_sample_value = '0;
    logic                    i_cfg_we       = 1'b0;
    logic [CFGI_W-1:0]       i_cfg_idx      = CFG_SEGMENT_LIMIT;
    logic [CFGD_W-1:0]       i_cfg_data     = '0;
    logic                    i_stall        = 1'b0;
    logic                    o_stall;
    logic                    o_valid;
    logic [WAV_W-1:0]        o_waveform_number;
    logic [PNT_W-1:0]        o_point_number;
    logic [2:0]              o_point_kind;
    logic [OFF_W-1:0]        o_sample_offset;
    logic signed [SMP_W-1:0] o_point_sample;
    logic                    o_last_point;
    logic                    o_measurement_done;

    point_scoreboard sb;
    int unsigned     words_sent;
    int unsigned     tx_idle_pct;
    int unsigned     rx_stall_pct;
    int unsigned     cycle_count;

    impulse_segmenter_extrema_marker_unit u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_req_type         (i_req_type),
        .i_sample_value     (i_sample_value),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_waveform_number  (o_waveform_number),
        .o_point_number     (o_point_number),
        .o_point_kind       (o_point_kind),
        .o_sample_offset    (o_sample_offset),
        .o_point_sample     (o_point_sample),
        .o_last_point       (o_last_point),
        .o_measurement_done (o_measurement_done)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver back-pressure, redrawn every cycle.
    always @(posedge i_clk)
        i_stall <= ($urandom_range(0, 99) < rx_stall_pct);

    // Output monitor: a point word moves on an edge with o_valid up and
    // i_stall down. Values read here are the ones present at the edge.
    always @(posedge i_clk)
        if (i_rst_n && o_valid && !i_stall)
            sb.check_point('{wnum: o_waveform_number, pnum: o_point_number,
                             kind: o_point_kind, off: o_sample_offset,
                             smp: o_point_sample, last: o_last_point,
                             done: o_measurement_done});

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("impulse_segmenter_extrema_marker_unit test failed");
            $finish;
        end
    end

    // Offer one word; returns on the edge that accepts it. Valid stays up
    // so a following word can go out back to back.
    task automatic send_word(input bit req, input logic signed [SMP_W-1:0] smp);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_req_type     <= req;
        i_sample_value <= smp;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        sb.predict_points(req, smp);
        words_sent++;
    endtask

    // Hold the sender until every pending point word is out, then let the
    // pipeline settle (a sample may close a segment that emits nothing).
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_points.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg r, input int unsigned v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= r;
        i_cfg_data <= CFGD_W'(v);
        @(posedge i_clk);
        sb.set_register(r, v);
    endtask

    task automatic apply_settings(input t_phase ph);
        write_reg(CFG_SEGMENT_LIMIT, ph.lim);
        write_reg(CFG_MIN_IMPULSE_LEN, ph.min_len);
        write_reg(CFG_END_LEVEL, ph.end_lvl);
        write_reg(CFG_MAX_POINTS, ph.pcap);
        write_reg(CFG_TARGET_WAVEFORMS, ph.target);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_idle(input t_idle_mode m);
        case (m)
            MODE_RX_HEAVY: begin tx_idle_pct = 29; rx_stall_pct = 77; end
            MODE_TX_HEAVY: begin tx_idle_pct = 77; rx_stall_pct = 29; end
            default:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        endcase
    endtask

    // |x| at or above the end level (for levels up to 32767), so the impulse keeps going
    function automatic logic signed [SMP_W-1:0] loud_sample(int unsigned lvl, bit pos_only);
        int unsigned mag;
        mag = (lvl > 32767) ? $urandom_range(0, 32767) : $urandom_range(32767, lvl);
        if (!pos_only && $urandom_range(0, 1))
            return SMP_W'(-int'(mag));
        return SMP_W'(mag);
    endfunction

    // |x| below a nonzero end level, closes the impulse once enough is stored; a zero level gives any value
    function automatic logic signed [SMP_W-1:0] quiet_sample(int unsigned lvl);
        int unsigned mag;
        if (lvl == 0)
            return SMP_W'($urandom);
        mag = $urandom_range(0, (lvl > 32768) ? 32767 : lvl - 1);
        return $urandom_range(0, 1) ? SMP_W'(-int'(mag)) : SMP_W'(mag);
    endfunction

    // One stretch of stimulus. Mostly whole impulses: a negative sample,
    // a nonnegative crossing, a loud body long enough to pass the minimum
    // length, then a quiet sample. The rest is noise, cut-short impulses
    // and start requests. With a limit too small for any waveform the
    // bodies stay short.
    task automatic run_episode(input t_phase ph, input bit allow_start);
        int unsigned             pick;
        int unsigned             body_len;
        int unsigned             i;
        bit                      sparse;
        logic signed [SMP_W-1:0] base;
        pick = $urandom_range(0, allow_start ? 9 : 7);
        if (pick <= 6 || pick == 8) begin
            if (pick == 8 || ph.lim < MIN_SEGMENT)
                body_len = $urandom_range(1, 30);
            else
                body_len = ((ph.min_len + 1 > MIN_SEGMENT) ? ph.min_len + 1 : MIN_SEGMENT)
                           + $urandom_range(0, 12);
            // sparse bodies: flat with a few spikes, so the end point fits
            sparse = (body_len > 1000) || $urandom_range(0, 1);
            base   = loud_sample(ph.end_lvl, 1'b0);
            send_word(REQ_SAMPLE, SMP_W'(-int'($urandom_range(1, 32768))));
            send_word(REQ_SAMPLE, loud_sample(ph.end_lvl, 1'b1));
            for (i = 1; i < body_len; i++)
                send_word(REQ_SAMPLE,
                          (sparse && $urandom_range(0, body_len / 4) != 0) ?
                          base : loud_sample(ph.end_lvl, 1'b0));
            send_word(REQ_SAMPLE, quiet_sample(ph.end_lvl));
        end else if (pick == 7) begin
            repeat ($urandom_range(1, 20))
                send_word(REQ_SAMPLE, SMP_W'($urandom));
        end else begin
            send_word(REQ_START, SMP_W'($urandom));
            // now and then the sender holds off until all points are out
            if ($urandom_range(0, 2) == 0)
                wait_drained();
        end
    endtask

    // Register settings per phase, extremes included:
    //   0  quick 101-sample segments, limit and cap above range,
    //      target below ten
    //   1  zero segment limit: impulse opens but never ends
    //   2  narrow limit window, cap below two
    //   3  one-sample limit: short segments only, count never moves
    function automatic t_phase phase_plan(int unsigned p);
        t_phase ph;
        case (p)
            0:       ph = '{8191, 100,  32768, 63, 0,    100, MODE_RX_HEAVY};
            1:       ph = '{0,    0,    0,     0,  1023, 10,  MODE_RX_HEAVY};
            2:       ph = '{150,  100,  500,   1,  10,   100, MODE_TX_HEAVY};
            default: ph = '{1,    0,    1000,  2,  1023, 10,  MODE_FREE};
        endcase
        return ph;
    endfunction

    initial begin : stimulus
        t_phase      ph;
        int unsigned first_word;
        sb = new;
        set_idle(MODE_RX_HEAVY);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: samples before any start are dropped, then a start,
        // a crossing exactly at zero, full-scale swings and a start request
        // in the middle of an open impulse.
        send_word(REQ_SAMPLE, 16'sh8000);
        send_word(REQ_SAMPLE, 16'sh7FFF);
        send_word(REQ_START,  16'sh7FFF);
        send_word(REQ_SAMPLE, 16'shFFFF);
        send_word(REQ_SAMPLE, 16'sh0000);
        repeat (3) begin
            send_word(REQ_SAMPLE, 16'sh7FFF);
            send_word(REQ_SAMPLE, 16'sh8000);
        end
        send_word(REQ_SAMPLE, 16'sh0001);
        send_word(REQ_SAMPLE, 16'shFFFE);
        send_word(REQ_START,  16'sh8000);
        send_word(REQ_SAMPLE, 16'sh8000);
        send_word(REQ_SAMPLE, 16'sh7FFF);
        send_word(REQ_SAMPLE, 16'sh8000);
        send_word(REQ_SAMPLE, 16'sh0000);

        // Random phases; registers change only with no point word pending.
        for (int unsigned p = 0; p < 4; p++) begin
            ph = phase_plan(p);
            wait_drained();
            set_idle(ph.mode);
            apply_settings(ph);
            send_word(REQ_START, SMP_W'($urandom));
            first_word = words_sent;
            while (words_sent - first_word < ph.budget)
                run_episode(ph, 1'b1);
        end

        wait_drained();
        if (sb.failures == 0)
            $display("impulse_segmenter_extrema_marker_unit test passed");
        else
            $display("impulse_segmenter_extrema_marker_unit test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/ise_pkg.sv
hw/rtl/ise_front.sv
hw/rtl/ise_queue.sv
hw/rtl/ise_back.sv
hw/rtl/impulse_segmenter_extrema_marker_unit.sv
test/impulse_segmenter_extrema_marker_unit_tb.sv
